// File: design/moving_average_warmup_core_defines.svh
// Assertion shorthands used by the moving-average core.
`ifndef MOVING_AVERAGE_WARMUP_CORE_DEFINES_SVH
`define MOVING_AVERAGE_WARMUP_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge.
`define MAVG_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("moving average core: same-cycle check failed");

// Next-cycle implication, checked on the rising clock edge.
`define MAVG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("moving average core: next-cycle check failed");

`endif

// File: design/mavg_pkg.sv
`default_nettype none
package mavg_pkg;

  localparam int ANGLE_W        = 16;
  localparam int WINDOW_DEFAULT = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_SUB,
    ST_DIV
  } mavg_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: design/mavg_if.sv
`default_nettype none
interface mavg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mavg_pkg::ANGLE_W-1:0] angle_sample;

  modport source (output valid, output angle_sample, input ready);
  modport sink   (input valid, input angle_sample, output ready);
endinterface

interface mavg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mavg_pkg::ANGLE_W-1:0] filtered_angle;

  modport source (output valid, output filtered_angle, input ready);
  modport sink   (input valid, input filtered_angle, output ready);
endinterface
`default_nettype wire

// File: design/moving_average_warmup_core.sv
`default_nettype none
// Moving-average filter for signed Q4.12 joint angles. Every accepted angle_sample
// enters a circular window of the last WINDOW samples and yields one filtered_angle,
// the mean of the samples held so far, truncated toward zero; until WINDOW samples
// have arrived since reset the divisor is the count seen. Each quotient comes from the
// one-bit-per-cycle restoring divider; the running sum is updated through a single
// shared adder, first in ST_ADD and then in ST_SUB. in_chan.ready is high only while
// the sequencer is idle. A finished result waits in the output register; the next item
// is still accepted, but its own result is held in ST_DIV until that register is free.
module moving_average_warmup_core #(
  parameter int WINDOW = mavg_pkg::WINDOW_DEFAULT
) (
  input wire logic clk,
  input wire logic rst_n,
  mavg_in_if.sink    in_chan,
  mavg_out_if.source out_chan
);

  `include "moving_average_warmup_core_defines.svh"

  localparam int AW   = mavg_pkg::ANGLE_W;
  localparam int SUMW = AW + $clog2(WINDOW);
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int PTRW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  mavg_pkg::mavg_state_t state_r, state_nxt;

  logic signed [AW-1:0]   win_mem [WINDOW];
  logic signed [AW-1:0]   x_r;
  logic signed [AW-1:0]   old_r;
  logic signed [SUMW-1:0] sum_r;
  logic signed [SUMW-1:0] sum_nxt;
  logic signed [SUMW-1:0] add_b;
  logic        [CNTW-1:0] seen_r;
  logic        [PTRW-1:0] ptr_r;
  logic                   full_r;
  logic                   out_valid_r;
  logic signed [AW-1:0]   out_data_r;

  logic                   in_accept;
  logic                   slot_free;
  logic                   in_ready;
  logic                   do_add;
  logic                   do_sub;
  logic                   div_start;
  logic                   out_load;

  mavg_pkg::div_stat_t    div_stat;
  logic signed [SUMW-1:0] div_quo;

  assign in_accept = in_chan.valid && in_ready;
  assign slot_free = !out_valid_r || out_chan.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mavg_pkg::ST_IDLE: if (in_accept) state_nxt = mavg_pkg::ST_ADD;
      mavg_pkg::ST_ADD:  state_nxt = mavg_pkg::ST_SUB;
      mavg_pkg::ST_SUB:  state_nxt = mavg_pkg::ST_DIV;
      mavg_pkg::ST_DIV:  if (div_stat.done && slot_free) state_nxt = mavg_pkg::ST_IDLE;
      default:           state_nxt = mavg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    do_add    = 1'b0;
    do_sub    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      mavg_pkg::ST_IDLE: in_ready  = 1'b1;
      mavg_pkg::ST_ADD:  do_add    = 1'b1;
      mavg_pkg::ST_SUB: begin
        do_sub    = 1'b1;
        div_start = 1'b1;
      end
      mavg_pkg::ST_DIV:  out_load  = div_stat.done && slot_free;
      default: ;
    endcase
  end

  // Shared adder: add the new sample, then drop the displaced one once full.
  always_comb begin
    if (do_add) begin
      add_b = signed'(SUMW'(x_r));
    end else if (full_r) begin
      add_b = signed'(SUMW'(old_r));
    end else begin
      add_b = '0;
    end
    sum_nxt = do_sub ? (sum_r - add_b) : (sum_r + add_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mavg_pkg::ST_IDLE;
      sum_r       <= '0;
      seen_r      <= '0;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_add || do_sub) begin
        sum_r <= sum_nxt;
      end
      if (do_add) begin
        full_r <= (seen_r == CNTW'(WINDOW));
        if (seen_r != CNTW'(WINDOW)) begin
          seen_r <= seen_r + CNTW'(1);
        end
        ptr_r <= (ptr_r == PTRW'(WINDOW - 1)) ? '0 : ptr_r + PTRW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      x_r <= in_chan.angle_sample;
    end
    if (out_load) begin
      out_data_r <= div_quo[AW-1:0];
    end
  end

  // Sample window: fetch the entry about to be displaced, then overwrite it.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      old_r <= win_mem[ptr_r];
    end
    if (do_add) begin
      win_mem[ptr_r] <= x_r;
    end
  end

  mavg_div #(
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (seen_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.filtered_angle = out_data_r;

  `MAVG_ASSERT_NOW(a_seen_bound, 1'b1, seen_r <= CNTW'(WINDOW))
  `MAVG_ASSERT_NOW(a_div_idle_on_start, div_start, !div_stat.busy && seen_r != '0)
  `MAVG_ASSERT_NEXT(a_accept_starts_add, in_accept, state_r == mavg_pkg::ST_ADD)
  `MAVG_ASSERT_NEXT(a_load_shows_result, out_load, out_valid_r && state_r == mavg_pkg::ST_IDLE)

endmodule
`default_nettype wire

// File: design/mavg_div.sv
`default_nettype none
module mavg_div #(
  parameter int SUMW = 19,
  parameter int CNTW = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [SUMW-1:0] dividend,
  input  wire logic        [CNTW-1:0] divisor,
  output mavg_pkg::div_stat_t         stat,
  output logic signed      [SUMW-1:0] quotient
);

  localparam int STEPW = $clog2(SUMW + 1);

  logic [SUMW-1:0]  quo_r;
  logic [CNTW-1:0]  rem_r;
  logic [CNTW-1:0]  dvs_r;
  logic             neg_r;
  logic [STEPW-1:0] step_r;
  logic             busy_r;
  logic             done_r;

  logic [CNTW:0]    trial;
  logic [CNTW:0]    diff;
  logic             ge;
  logic [CNTW-1:0]  rem_nxt;
  logic [SUMW-1:0]  quo_nxt;
  logic [SUMW-1:0]  mag;

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial   = {rem_r, quo_r[SUMW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = ~diff[CNTW];
    rem_nxt = ge ? diff[CNTW-1:0] : trial[CNTW-1:0];
    quo_nxt = {quo_r[SUMW-2:0], ge};
    mag     = dividend[SUMW-1] ? (~dividend + SUMW'(1)) : dividend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEPW'(SUMW);
    end else if (busy_r) begin
      step_r <= step_r - STEPW'(1);
      if (step_r == STEPW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SUMW-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  // Apply the sign afterwards so the quotient truncates toward zero.
  assign quotient  = neg_r ? -signed'(quo_r) : signed'(quo_r);

endmodule
`default_nettype wire

// File: tb/moving_average_warmup_core_tb.sv
`timescale 1ns / 1ps

class angle_average_scoreboard;
  localparam int WINDOW = mavg_pkg::WINDOW_DEFAULT;

  logic signed [15:0] held_samples[WINDOW];
  int                 running_sum  = 0;
  int                 held_count   = 0;
  int                 wr_slot      = 0;
  logic signed [15:0] pending_means[$];
  int                 samples_noted = 0;
  int                 means_checked = 0;
  int                 mismatches    = 0;

  // Advance the window with one accepted sample and queue the mean it yields.
  function void note_sample(logic signed [15:0] sample);
    int mean;
    if (held_count < WINDOW) begin
      running_sum = running_sum + sample;
      held_count++;
    end else begin
      running_sum = running_sum + sample - held_samples[wr_slot];
    end
    held_samples[wr_slot] = sample;
    wr_slot = (wr_slot + 1) % WINDOW;
    // Integer division truncates toward zero, as the filter does.
    mean = running_sum / held_count;
    pending_means.push_back(mean[15:0]);
    samples_noted++;
  endfunction

  function void check_mean(logic signed [15:0] actual);
    logic signed [15:0] expected;
    if (pending_means.size() == 0) begin
      $error("filtered_angle: no result expected, actual %0d", actual);
      mismatches++;
    end else begin
      expected = pending_means.pop_front();
      means_checked++;
      if (actual !== expected) begin
        $error("filtered_angle: expected %0d, actual %0d", expected, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module moving_average_warmup_core_tb;
  localparam int WINDOW         = mavg_pkg::WINDOW_DEFAULT;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int QUIET_ITEMS    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;
  int   out_stall_left = 0;
  int   idle_cycles = 0;
  int   items_sent = 0;

  angle_average_scoreboard sb;

  mavg_in_if  in_chan();
  mavg_out_if out_chan();

  moving_average_warmup_core #(.WINDOW(WINDOW)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold valid until the item is taken; the caller decides whether to drop it.
  task automatic send_angle(input logic signed [15:0] sample);
    in_chan.valid        <= 1'b1;
    in_chan.angle_sample <= sample;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] random_angle();
    int pick;
    int value;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      value = $urandom_range(0, 65535);
    else if (pick < 8)
      value = int'($urandom_range(0, 32)) - 16;
    else if (pick == 8)
      value = -32768;
    else
      value = 32767;
    return value[15:0];
  endfunction

  // Output side: ready drops at random, and no new drop starts once quiet.
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_stall_left <= $urandom_range(0, 2);
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        sb.note_sample(in_chan.angle_sample);
      if (out_chan.valid && out_chan.ready)
        sb.check_mean(out_chan.filtered_angle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int directed[] = '{-1, 0,
                       -32768, -32768, -32768, -32768, -32768, -32768,
                       -32768, -32768, -32768, -32768, -32768, -32768,
                       32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                       1, -3, 21845};
    int run_len;
    int base;
    sb = new;
    in_chan.valid        = 1'b0;
    in_chan.angle_sample = '0;
    out_chan.ready       = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Warm-up from reset, truncation of negative means, saturated window at both rails.
    foreach (directed[i]) begin
      send_angle(directed[i][15:0]);
      maybe_idle();
    end

    while (items_sent < directed.size() + RANDOM_ITEMS) begin
      if (items_sent >= directed.size() + RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        // Fill the whole window near one rail to reach the extreme sums.
        run_len = $urandom_range(WINDOW, WINDOW + 4);
        base    = $urandom_range(0, 1) ? 32767 : -32768;
        repeat (run_len) begin
          send_angle(base > 0 ? 16'(base - $urandom_range(0, 3))
                              : 16'(base + $urandom_range(0, 3)));
          maybe_idle();
        end
      end else begin
        send_angle(random_angle());
        maybe_idle();
      end
    end
    in_chan.valid <= 1'b0;

    while (sb.pending_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered warm-up from reset, full-window sums at both rails and random angles");
    $display("%0d samples sent, %0d filtered angles checked, %0d mismatches",
             sb.samples_noted, sb.means_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_means.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
